FILE: hw/rtl/fcl_pkg.sv
// ----------------------------------------------------------------------------
// fcl_pkg: shared types and helpers for the friction contact local solver
// Fixed widths, sideband struct and the Q16.16 saturating clamp.
// ----------------------------------------------------------------------------
package fcl_pkg;

	localparam int DW     = 32;  // data word, Q16.16
	localparam int FB     = 16;  // fraction bits
	localparam int MUW    = 31;  // friction coefficient and threshold width
	localparam int NUM_W  = 66;  // divider numerator and denominator width
	localparam int REM_W  = 98;  // divider remainder width
	localparam int QBITS  = 32;  // quotient bits resolved by the divider
	localparam int MAG_W  = 48;  // magnitude width entering the clamp

	localparam logic [MAG_W-1:0] HALF_MAG = MAG_W'(64'h8000_0000);

	// Item context that travels beside the arithmetic
	typedef struct packed {
		logic                  open;
		logic                  sing;
		logic                  outside;
		logic                  lower;
		logic [MUW-1:0]        mu;
		logic signed [DW-1:0]  nn;
		logic signed [DW-1:0]  nt;
		logic signed [DW-1:0]  qn;
		logic signed [DW-1:0]  pn;
		logic signed [DW-1:0]  pt;
	} side_t;

	// Saturate a sign and magnitude pair into a signed word
	function automatic logic [DW-1:0] clamp_q(input logic neg, input logic [MAG_W-1:0] mag);
		logic [MAG_W-1:0] m;
		logic [MAG_W-1:0] n;
		if (neg && (mag != '0)) begin
			m = (mag > HALF_MAG) ? HALF_MAG : mag;
			n = MAG_W'(0) - m;
			clamp_q = n[DW-1:0];
		end else begin
			m = (mag > (HALF_MAG - MAG_W'(1))) ? (HALF_MAG - MAG_W'(1)) : mag;
			clamp_q = m[DW-1:0];
		end
	endfunction

endpackage

FILE: hw/rtl/fcl_div.sv
// ----------------------------------------------------------------------------
// fcl_div: pipelined saturating fixed point divider
// Computes (num << 16) / den truncated toward zero, one quotient bit a stage.
// ----------------------------------------------------------------------------
module fcl_div (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	input  logic signed [fcl_pkg::NUM_W-1:0]   in_num,
	input  logic signed [fcl_pkg::NUM_W-1:0]   in_den,
	input  fcl_pkg::side_t                     in_side,
	output logic                               out_valid,
	output logic signed [fcl_pkg::DW-1:0]      out_q,
	output fcl_pkg::side_t                     out_side
);
	import fcl_pkg::*;

	logic               vld_s1;
	logic [NUM_W-1:0]   nmag_s1;
	logic [NUM_W-1:0]   dmag_s1;
	logic               neg_s1;
	side_t              side_s1;

	logic               vld_s [0:QBITS];
	logic [REM_W-1:0]   rem_s [0:QBITS];
	logic [NUM_W-1:0]   dmag_s [0:QBITS];
	logic [QBITS-1:0]   quo_s [0:QBITS];
	logic               neg_s [0:QBITS];
	logic               nz_s [0:QBITS];
	logic               sat_s [0:QBITS];
	side_t              side_s [0:QBITS];

	logic [REM_W-1:0]   nwide;
	logic [REM_W-1:0]   dtop;
	logic [MAG_W-1:0]   fmag;

	// Take magnitudes and the quotient sign
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		nmag_s1 <= in_num[NUM_W-1] ? NUM_W'(-in_num) : NUM_W'(in_num);
		dmag_s1 <= in_den[NUM_W-1] ? NUM_W'(-in_den) : NUM_W'(in_den);
		neg_s1  <= in_num[NUM_W-1] ^ in_den[NUM_W-1];
		side_s1 <= in_side;
	end

	// Detect overflow of the quotient range and seed the remainder
	assign nwide = REM_W'({nmag_s1, FB'(0)});
	assign dtop  = REM_W'(dmag_s1) << QBITS;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s[0] <= 1'b0;
		end else begin
			vld_s[0] <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		rem_s[0]  <= nwide;
		dmag_s[0] <= dmag_s1;
		quo_s[0]  <= '0;
		neg_s[0]  <= neg_s1;
		nz_s[0]   <= (nmag_s1 != '0);
		sat_s[0]  <= (nwide >= dtop);
		side_s[0] <= side_s1;
	end

	// Resolve one quotient bit per stage, most significant first
	for (genvar j = 0; j < QBITS; j++) begin : g_bit
		localparam int SH = QBITS - 1 - j;
		logic [REM_W:0] diff;

		assign diff = {1'b0, rem_s[j]} - {1'b0, REM_W'(dmag_s[j]) << SH};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[j+1] <= 1'b0;
			end else begin
				vld_s[j+1] <= vld_s[j];
			end
		end

		always_ff @(posedge clk) begin
			rem_s[j+1]  <= diff[REM_W] ? rem_s[j] : diff[REM_W-1:0];
			quo_s[j+1]  <= {quo_s[j][QBITS-2:0], ~diff[REM_W]};
			dmag_s[j+1] <= dmag_s[j];
			neg_s[j+1]  <= neg_s[j];
			nz_s[j+1]   <= nz_s[j];
			sat_s[j+1]  <= sat_s[j];
			side_s[j+1] <= side_s[j];
		end
	end

	// Saturate and sign the quotient
	assign fmag = sat_s[QBITS] ? '1 : MAG_W'(quo_s[QBITS]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else begin
			out_valid <= vld_s[QBITS];
		end
	end

	always_ff @(posedge clk) begin
		out_q    <= nz_s[QBITS] ? clamp_q(neg_s[QBITS], fmag) : '0;
		out_side <= side_s[QBITS];
	end

endmodule

FILE: hw/rtl/fcl_front.sv
// ----------------------------------------------------------------------------
// fcl_front: matrix products, determinant and Cramer numerators
// Two stages: six products, then determinant, numerators and singular test.
// ----------------------------------------------------------------------------
module fcl_front (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	input  logic signed [fcl_pkg::DW-1:0]      w_nn,
	input  logic signed [fcl_pkg::DW-1:0]      w_tn,
	input  logic signed [fcl_pkg::DW-1:0]      w_nt,
	input  logic signed [fcl_pkg::DW-1:0]      w_tt,
	input  logic signed [fcl_pkg::DW-1:0]      q_normal,
	input  logic signed [fcl_pkg::DW-1:0]      q_tangent,
	input  logic [fcl_pkg::MUW-1:0]            friction_coeff,
	input  logic [fcl_pkg::MUW-1:0]            thr,
	output logic                               out_valid,
	output logic signed [fcl_pkg::NUM_W-1:0]   num_n,
	output logic signed [fcl_pkg::NUM_W-1:0]   num_t,
	output logic signed [fcl_pkg::NUM_W-1:0]   det,
	output fcl_pkg::side_t                     out_side
);
	import fcl_pkg::*;

	logic                     vld_s1;
	logic signed [2*DW-1:0]   nntt_s1, nttn_s1, ntqt_s1, ttqn_s1, tnqn_s1, nnqt_s1;
	side_t                    side_s1;
	side_t                    side_nx;
	logic signed [NUM_W-1:0]  det_c;

	// Form the six exact products
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		nntt_s1 <= w_nn * w_tt;
		nttn_s1 <= w_nt * w_tn;
		ntqt_s1 <= w_nt * q_tangent;
		ttqn_s1 <= w_tt * q_normal;
		tnqn_s1 <= w_tn * q_normal;
		nnqt_s1 <= w_nn * q_tangent;
		side_s1 <= '{open: (!q_normal[DW-1] && (q_normal != '0)), sing: 1'b0,
			outside: 1'b0, lower: 1'b0, mu: friction_coeff, nn: w_nn, nt: w_nt,
			qn: q_normal, pn: '0, pt: '0};
	end

	// Subtract into determinant and numerators, test the threshold
	assign det_c = NUM_W'(nntt_s1) - NUM_W'(nttn_s1);

	always_comb begin
		side_nx      = side_s1;
		side_nx.sing = det_c < $signed({(NUM_W-MUW-FB)'(0), thr, FB'(0)});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else begin
			out_valid <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		det      <= det_c;
		num_n    <= NUM_W'(ntqt_s1) - NUM_W'(ttqn_s1);
		num_t    <= NUM_W'(tnqn_s1) - NUM_W'(nnqt_s1);
		out_side <= side_nx;
	end

endmodule

FILE: hw/rtl/fcl_cone.sv
// ----------------------------------------------------------------------------
// fcl_cone: friction cone test and sliding denominator
// Two stages: mu products, then cone test, edge choice and edge quotient terms.
// ----------------------------------------------------------------------------
module fcl_cone (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	input  logic signed [fcl_pkg::DW-1:0]      pn,
	input  logic signed [fcl_pkg::DW-1:0]      pt,
	input  fcl_pkg::side_t                     in_side,
	output logic                               out_valid,
	output logic signed [fcl_pkg::NUM_W-1:0]   num,
	output logic signed [fcl_pkg::NUM_W-1:0]   den,
	output fcl_pkg::side_t                     out_side
);
	import fcl_pkg::*;

	logic                     vld_s1;
	logic signed [2*DW-1:0]   mupn_s1;
	logic signed [2*DW-1:0]   muw_s1;
	side_t                    side_s1;
	side_t                    side_in;

	logic [DW:0]              apt;
	logic signed [NUM_W-1:0]  ptw;
	logic signed [NUM_W-1:0]  nnw;
	logic signed [NUM_W-1:0]  mupnw;
	logic signed [NUM_W-1:0]  muww;
	logic                     lower_c;
	side_t                    side_nx;

	// Attach the solved impulses to the item context
	always_comb begin
		side_in    = in_side;
		side_in.pn = pn;
		side_in.pt = pt;
	end

	// Scale the normal impulse and the coupling term by mu
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		mupn_s1 <= $signed({1'b0, in_side.mu}) * pn;
		muw_s1  <= $signed({1'b0, in_side.mu}) * in_side.nt;
		side_s1 <= side_in;
	end

	// Test the cone and pick the edge
	assign apt     = side_s1.pt[DW-1] ? (DW+1)'(-side_s1.pt) : (DW+1)'(side_s1.pt);
	assign ptw     = NUM_W'($signed({side_s1.pt, FB'(0)}));
	assign nnw     = NUM_W'($signed({side_s1.nn, FB'(0)}));
	assign mupnw   = NUM_W'(mupn_s1);
	assign muww    = NUM_W'(muw_s1);
	assign lower_c = (ptw + mupnw) < 0;

	always_comb begin
		side_nx         = side_s1;
		side_nx.outside = $signed({(NUM_W-DW-1-FB)'(0), apt, FB'(0)}) > mupnw;
		side_nx.lower   = lower_c;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else begin
			out_valid <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		num      <= NUM_W'(0) - NUM_W'($signed({side_s1.qn, FB'(0)}));
		den      <= lower_c ? (nnw - muww) : (nnw + muww);
		out_side <= side_nx;
	end

endmodule

FILE: hw/rtl/friction_contact_2d_local_solve.sv
// ----------------------------------------------------------------------------
// friction_contact_2d_local_solve: 2-D Coulomb contact local solver
// Fully pipelined: one contact enters per clock, one result leaves per item.
// ----------------------------------------------------------------------------
// Usage:
//   Drive the seven contact fields and pulse start; an item is taken on any
//   edge where start is high. busy stays low, so a new contact may enter in
//   every cycle.
//   Each result appears on impulse_normal, impulse_tangent and status for one
//   cycle with done high, in entry order.
//   The receiver has no way to hold results off and none is needed.
//   The path runs through two 35-stage dividers (one quotient bit per stage) in
//   series, with two stages ahead of each and two at the end.
//   singular_threshold is written through cfg_valid/cfg_ready/cfg_data;
//   cfg_ready is always high. Write it only while no item is in flight.
//   Reset clears every valid bit and sets the threshold to 1; results in
//   flight are dropped.
// ----------------------------------------------------------------------------
module friction_contact_2d_local_solve (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	output logic                            busy,
	input  logic signed [fcl_pkg::DW-1:0]   w_nn,
	input  logic signed [fcl_pkg::DW-1:0]   w_tn,
	input  logic signed [fcl_pkg::DW-1:0]   w_nt,
	input  logic signed [fcl_pkg::DW-1:0]   w_tt,
	input  logic signed [fcl_pkg::DW-1:0]   q_normal,
	input  logic signed [fcl_pkg::DW-1:0]   q_tangent,
	input  logic [fcl_pkg::MUW-1:0]         friction_coeff,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [fcl_pkg::MUW-1:0]         cfg_data,
	output logic                            done,
	output logic signed [fcl_pkg::DW-1:0]   impulse_normal,
	output logic signed [fcl_pkg::DW-1:0]   impulse_tangent,
	output logic                            status
);
	import fcl_pkg::*;

	logic [MUW-1:0]           thr_q;

	logic                     fr_valid;
	logic signed [NUM_W-1:0]  fr_num_n, fr_num_t, fr_det;
	side_t                    fr_side;

	logic                     dn_valid;
	logic signed [DW-1:0]     dn_q;
	side_t                    dn_side;
	logic                     dt_valid;
	logic signed [DW-1:0]     dt_q;

	logic                     cn_valid;
	logic signed [NUM_W-1:0]  cn_num, cn_den;
	side_t                    cn_side;

	logic                     de_valid;
	logic signed [DW-1:0]     de_q;
	side_t                    de_side;

	logic                     vld_s1;
	logic signed [2*DW-1:0]   prod_s1;
	logic signed [DW-1:0]     pne_s1;
	side_t                    side_s1;

	logic                     pneg;
	logic [2*DW-1:0]          pabs;
	logic [DW-1:0]            pte;

	// Hold the threshold register
	assign cfg_ready = 1'b1;
	assign busy      = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= MUW'(1);
		end else if (cfg_valid && cfg_ready) begin
			thr_q <= cfg_data;
		end
	end

	fcl_front u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (start && !busy),
		.w_nn           (w_nn),
		.w_tn           (w_tn),
		.w_nt           (w_nt),
		.w_tt           (w_tt),
		.q_normal       (q_normal),
		.q_tangent      (q_tangent),
		.friction_coeff (friction_coeff),
		.thr            (thr_q),
		.out_valid      (fr_valid),
		.num_n          (fr_num_n),
		.num_t          (fr_num_t),
		.det            (fr_det),
		.out_side       (fr_side)
	);

	// Solve both impulses in parallel
	fcl_div u_div_n (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (fr_valid),
		.in_num    (fr_num_n),
		.in_den    (fr_det),
		.in_side   (fr_side),
		.out_valid (dn_valid),
		.out_q     (dn_q),
		.out_side  (dn_side)
	);

	fcl_div u_div_t (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (fr_valid),
		.in_num    (fr_num_t),
		.in_den    (fr_det),
		.in_side   (fr_side),
		.out_valid (dt_valid),
		.out_q     (dt_q),
		.out_side  ()
	);

	fcl_cone u_cone (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (dn_valid && dt_valid),
		.pn        (dn_q),
		.pt        (dt_q),
		.in_side   (dn_side),
		.out_valid (cn_valid),
		.num       (cn_num),
		.den       (cn_den),
		.out_side  (cn_side)
	);

	// Sliding normal impulse on the chosen edge
	fcl_div u_div_e (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (cn_valid),
		.in_num    (cn_num),
		.in_den    (cn_den),
		.in_side   (cn_side),
		.out_valid (de_valid),
		.out_q     (de_q),
		.out_side  (de_side)
	);

	// Scale the edge normal impulse by mu
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= de_valid;
		end
	end

	always_ff @(posedge clk) begin
		prod_s1 <= $signed({1'b0, de_side.mu}) * de_q;
		pne_s1  <= de_q;
		side_s1 <= de_side;
	end

	// Truncate the edge tangent impulse and select the result
	assign pneg = prod_s1[2*DW-1];
	assign pabs = pneg ? (2*DW)'(-prod_s1) : (2*DW)'(prod_s1);
	assign pte  = clamp_q(pneg ^ side_s1.lower, pabs[2*DW-1:FB]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (side_s1.open || side_s1.sing) begin
			impulse_normal  <= '0;
			impulse_tangent <= '0;
		end else if (side_s1.outside) begin
			impulse_normal  <= pne_s1;
			impulse_tangent <= pte;
		end else begin
			impulse_normal  <= side_s1.pn;
			impulse_tangent <= side_s1.pt;
		end
		status <= !side_s1.open && side_s1.sing;
	end

endmodule

FILE: tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench: self-checking bench for friction_contact_2d_local_solve
// Drives contacts through start/busy and writes the singular threshold
// between phases. Each result is compared with a bit-exact predictor of the
// cone solve or a pinned typed answer, covering open, singular and sliding cases.
// ----------------------------------------------------------------------------
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import fcl_pkg::*;

	localparam int  N_RANDOM   = 1500;
	localparam int  DRAIN_WAIT = 120;
	localparam int  CYCLE_CAP  = 600000;
	localparam int  N_ROWS     = 14;
	localparam logic [MUW-1:0] THR_MAX = '1;

	typedef logic signed [159:0] wide_t;

	typedef struct packed {
		logic signed [DW-1:0] w_nn;
		logic signed [DW-1:0] w_tn;
		logic signed [DW-1:0] w_nt;
		logic signed [DW-1:0] w_tt;
		logic signed [DW-1:0] q_normal;
		logic signed [DW-1:0] q_tangent;
		logic [MUW-1:0]       mu;
	} contact_t;

	typedef struct packed {
		logic signed [DW-1:0] pn;
		logic signed [DW-1:0] pt;
		logic                 sing;
	} impulse_t;

	typedef struct packed {
		contact_t c;
		logic     typed;
		impulse_t want;
	} row_t;

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	logic signed [DW-1:0] w_nn, w_tn, w_nt, w_tt, q_normal, q_tangent;
	logic [MUW-1:0] friction_coeff;
	logic cfg_valid;
	logic cfg_ready;
	logic [MUW-1:0] cfg_data;
	logic done;
	logic signed [DW-1:0] impulse_normal;
	logic signed [DW-1:0] impulse_tangent;
	logic status;

	friction_contact_2d_local_solve dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.w_nn(w_nn), .w_tn(w_tn), .w_nt(w_nt), .w_tt(w_tt),
		.q_normal(q_normal), .q_tangent(q_tangent), .friction_coeff(friction_coeff),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
		.done(done), .impulse_normal(impulse_normal),
		.impulse_tangent(impulse_tangent), .status(status)
	);

	// Clock
	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	logic [MUW-1:0] threshold;
	impulse_t       pending_impulses[$];
	logic           pin_next;
	impulse_t       pinned[$];
	int             mismatches;
	int             cycles;
	bit             drive_fast;

	// Saturate a sign and magnitude into a Q16.16 word
	function automatic logic signed [DW-1:0] sat_q(input logic neg, input wide_t mag);
		if (neg && mag != 0)
			return (mag > (wide_t'(1) <<< 31)) ? 32'sh8000_0000 : DW'(-mag);
		return (mag > ((wide_t'(1) <<< 31) - 1)) ? 32'sh7fff_ffff : DW'(mag);
	endfunction

	// (num << 16) / den, truncated toward zero, saturated
	function automatic logic signed [DW-1:0] fixed_div(input wide_t num, input wide_t den);
		wide_t an;
		wide_t ad;
		an = (num < 0) ? -num : num;
		ad = (den < 0) ? -den : den;
		if (den == 0)
			return (num == 0) ? '0 : sat_q(num < 0, wide_t'(1) <<< 40);
		return sat_q((num < 0) != (den < 0), (an <<< FB) / ad);
	endfunction

	function automatic impulse_t solve_contact(input contact_t c, input logic [MUW-1:0] thr);
		wide_t nn, tn, nt, tt, qn, qt, mu, det, pnw, ptw, mupn, apt, den, prod;
		logic lower;
		impulse_t r;
		nn = wide_t'(c.w_nn);
		tn = wide_t'(c.w_tn);
		nt = wide_t'(c.w_nt);
		tt = wide_t'(c.w_tt);
		qn = wide_t'(c.q_normal);
		qt = wide_t'(c.q_tangent);
		mu = wide_t'({1'b0, c.mu});
		r = '0;
		if (qn > 0)
			return r;
		det = nn * tt - nt * tn;
		if (det < (wide_t'({1'b0, thr}) <<< FB)) begin
			r.sing = 1'b1;
			return r;
		end
		r.pn = fixed_div(-(tt * qn - nt * qt), det);
		r.pt = fixed_div(-(nn * qt - tn * qn), det);
		pnw = wide_t'(r.pn);
		ptw = wide_t'(r.pt);
		mupn = mu * pnw;
		apt = (ptw < 0) ? -ptw : ptw;
		// Outside the cone: slide on the edge picked by the sign of Pt + mu*Pn
		if ((apt <<< FB) > mupn) begin
			lower = ((ptw <<< FB) + mupn) < 0;
			den = (nn <<< FB) + (lower ? -(mu * nt) : mu * nt);
			r.pn = fixed_div(-(qn <<< FB), den);
			prod = mu * wide_t'(r.pn);
			r.pt = sat_q((prod < 0) != lower, ((prod < 0) ? -prod : prod) >>> FB);
		end
		return r;
	endfunction

	// Accept input beats and config writes
	always @(posedge clk) begin
		if (arst_n && cfg_valid && cfg_ready)
			threshold <= cfg_data;
		if (arst_n && start && !busy) begin
			if (pin_next)
				pending_impulses.push_back(pinned.pop_front());
			else
				pending_impulses.push_back(solve_contact(
					{w_nn, w_tn, w_nt, w_tt, q_normal, q_tangent, friction_coeff},
					threshold));
		end
	end

	// Check result beats
	always @(posedge clk) begin
		impulse_t exp_r;
		if (arst_n && done) begin
			if (pending_impulses.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result beat: pn=%h pt=%h st=%b",
						impulse_normal, impulse_tangent, status);
			end else begin
				exp_r = pending_impulses.pop_front();
				if (impulse_normal !== exp_r.pn || impulse_tangent !== exp_r.pt ||
						status !== exp_r.sing) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: exp pn=%h pt=%h st=%b got pn=%h pt=%h st=%b",
							exp_r.pn, exp_r.pt, exp_r.sing,
							impulse_normal, impulse_tangent, status);
				end
			end
		end
	end

	// Watchdog
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_CAP) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (drive_fast || r < 55)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// Drive one contact, holding start across back-to-back beats
	task automatic send_contact(input contact_t c, input int gap);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		w_nn <= c.w_nn;
		w_tn <= c.w_tn;
		w_nt <= c.w_nt;
		w_tt <= c.w_tt;
		q_normal <= c.q_normal;
		q_tangent <= c.q_tangent;
		friction_coeff <= c.mu;
		start <= 1'b1;
		do @(posedge clk); while (busy);
	endtask

	task automatic drain();
		start <= 1'b0;
		while (pending_impulses.size() != 0) @(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
	endtask

	task automatic write_threshold(input logic [MUW-1:0] v);
		cfg_data <= v;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	function automatic contact_t rand_contact();
		contact_t c;
		int k;
		k = $urandom_range(0, 9);
		if (k < 2) begin
			// Noise: any bit pattern
			c = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
				MUW'($urandom)};
		end else begin
			// Well-conditioned contact, pressing in but for k == 9, small Q16.16 values
			c.w_nn = $urandom_range(1 << 14, 8 << 16);
			c.w_tt = $urandom_range(1 << 14, 8 << 16);
			c.w_nt = $signed($urandom_range(0, 1 << 17)) - (1 << 16);
			c.w_tn = (k < 5) ? c.w_nt : $signed($urandom_range(0, 1 << 17)) - (1 << 16);
			c.q_normal = -$signed($urandom_range(0, 4 << 16));
			c.q_tangent = $signed($urandom_range(0, 8 << 16)) - (4 << 16);
			c.mu = MUW'($urandom_range(0, 2 << 16));
			if (k == 9)
				c.q_normal = $urandom_range(1, 1 << 18);
		end
		return c;
	endfunction

	row_t vectors[N_ROWS];

	initial begin
		logic [MUW-1:0] thr_set[4];
		contact_t c;
		cycles = 0;
		mismatches = 0;
		pin_next = 1'b0;
		drive_fast = 1'b0;
		threshold = 31'd1;
		start = 1'b0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		{w_nn, w_tn, w_nt, w_tt, q_normal, q_tangent} = '0;
		friction_coeff = '0;
		arst_n = 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed rows: typed where the answer is obvious
		vectors[0]  = '{'{32'sh10000, 0, 0, 32'sh10000, 32'sh1, 0, 31'h8000}, 1, '{0, 0, 0}};
		vectors[1]  = '{'{0, 0, 0, 0, 0, 0, 0}, 1, '{0, 0, 1}};
		vectors[2]  = '{'{0, 32'sh10000, 32'sh10000, 0, -32'sh10000, 0, 31'h8000},
			1, '{0, 0, 1}};
		vectors[3]  = '{'{32'sh10000, 0, 0, 32'sh10000, -32'sh10000, 0, 31'h8000},
			1, '{32'sh10000, 0, 0}};
		vectors[4]  = '{'{32'sh10000, 0, 0, 32'sh10000, -32'sh10000, -32'sh20000, 31'h8000},
			0, '0};
		vectors[5]  = '{'{32'sh10000, 0, 0, 32'sh10000, -32'sh10000, 32'sh20000, 31'h8000},
			0, '0};
		vectors[6]  = '{'{32'sh7fffffff, 0, 0, 32'sh7fffffff, 32'sh80000000,
			32'sh80000000, THR_MAX}, 0, '0};
		vectors[7]  = '{'{32'sh7fffffff, 32'sh80000000, 32'sh80000000, 32'sh7fffffff,
			32'sh7fffffff, 32'sh7fffffff, THR_MAX}, 1, '{0, 0, 0}};
		vectors[8]  = '{'{32'sh80000000, 32'sh7fffffff, 32'sh7fffffff, 32'sh80000000,
			0, 32'sh7fffffff, 0}, 0, '0};
		vectors[9]  = '{'{32'sh100, 0, 0, 32'sh100, -32'sh7fffffff, 32'sh7fffffff, 31'h1},
			0, '0};
		// Unit mu with w_nt of +1 and -1; both land inside the cone
		vectors[10] = '{'{32'sh10000, 0, 32'sh10000, 32'sh20000, -32'sh10000, 32'sh40000,
			31'h10000}, 0, '0};
		vectors[11] = '{'{32'sh10000, 0, -32'sh10000, 32'sh20000, -32'sh10000, -32'sh40000,
			31'h10000}, 0, '0};
		vectors[12] = '{'{32'sh10000, 0, 0, 32'sh10000, 0, 32'sh10000, 31'h10000}, 0, '0};
		vectors[13] = '{'{32'sh10000, 32'sh4000, 32'sh4000, 32'sh10000, -1, -1, THR_MAX},
			0, '0};

		foreach (vectors[i]) begin
			if (vectors[i].typed) begin
				pinned.push_back(vectors[i].want);
				pin_next <= 1'b1;
			end else begin
				pin_next <= 1'b0;
			end
			send_contact(vectors[i].c, pick_gap());
		end
		pin_next <= 1'b0;
		drain();

		// Random phases across threshold settings, extremes included
		thr_set[0] = 31'd0;
		thr_set[1] = THR_MAX;
		thr_set[2] = MUW'($urandom_range(0, 1 << 18));
		thr_set[3] = 31'd1;
		for (int p = 0; p < 4; p++) begin
			write_threshold(thr_set[p]);
			for (int n = 0; n < N_RANDOM / 4; n++) begin
				if (n % 64 == 0)
					drive_fast = ($urandom_range(0, 3) == 0);
				// Hold off once mid-phase until the pipe is empty
				if (n == 100 && p == 2)
					drain();
				c = rand_contact();
				send_contact(c, pick_gap());
			end
			drain();
		end

		if (mismatches == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

FILE: files.f
hw/rtl/fcl_pkg.sv
hw/rtl/fcl_div.sv
hw/rtl/fcl_front.sv
hw/rtl/fcl_cone.sv
hw/rtl/friction_contact_2d_local_solve.sv
tb/testbench.sv
